/* src/i2cps_pkg.sv */
package i2cps_pkg;

    // Input opcodes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_RESP  = 2'd2;
    localparam logic [1:0] OP_DATA  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_PAGE_SIZE_LOG2 = 2'd1;
    localparam logic [1:0] REG_CAPACITY       = 2'd2;

    // Reset values of the configuration registers
    localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd80;
    localparam logic [3:0] PAGE_SIZE_LOG2_RESET = 4'd3;
    localparam logic [8:0] CAPACITY_RESET       = 9'd256;

    // Largest page exponent (a 256-byte page)
    localparam logic [3:0] PAGE_LOG2_MAX = 4'd8;

    // Results produced by one request at most, and result queue depth
    localparam int MaxResults = 3;
    localparam int QDepth     = 4;
    localparam int QPtrW      = $clog2(QDepth);
    localparam int QCntW      = $clog2(QDepth + 1);

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEVACK   = 3'd1,
        PH_ADDRACK  = 3'd2,
        PH_NEEDDATA = 3'd3,
        PH_DATAACK  = 3'd4,
        PH_WAITDONE = 3'd5,
        PH_RDEVACK  = 3'd6,
        PH_RDATA    = 3'd7
    } phase_t;

    typedef enum logic [3:0] {
        CMD_START  = 4'd0,
        CMD_STOP   = 4'd1,
        CMD_SEND   = 4'd2,
        CMD_RDACK  = 4'd3,
        CMD_RDNACK = 4'd4,
        CMD_WAIT   = 4'd5,
        CMD_NEED   = 4'd6,
        CMD_RDOUT  = 4'd7,
        CMD_OK     = 4'd8,
        CMD_ERR    = 4'd9
    } cmd_t;

    typedef struct packed {
        logic [6:0] device_address;
        logic [3:0] page_size_log2;
        logic [8:0] capacity;
    } cfg_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] cur_addr;
        logic [8:0] bytes_left;
        logic [8:0] chunk_left;
        logic       is_read;
    } seq_state_t;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] byte_value;
        logic       last;
    } result_t;

    localparam result_t RESULT_NONE = '{command: CMD_OK, byte_value: 8'd0, last: 1'b0};

endpackage

/* src/i2cps_step.sv */
module i2cps_step
    import i2cps_pkg::*;
(
    input  seq_state_t cur,
    input  cfg_t       cfg,
    input  logic [1:0] opcode,
    input  logic [7:0] mem_address,
    input  logic [8:0] length,
    input  logic [7:0] data_byte,
    input  logic       ack,
    output seq_state_t nxt,
    output result_t    res [MaxResults],
    output logic [1:0] res_count
);

    // Bytes that fit before the next page boundary, capped by what is left
    function automatic logic [8:0] chunk_len(
        input logic [7:0] addr,
        input logic [8:0] bytes,
        input logic [3:0] psl2
    );
        logic [3:0] p;
        logic [8:0] page;
        logic [8:0] offs;
        logic [8:0] room;
        p    = (psl2 > PAGE_LOG2_MAX) ? PAGE_LOG2_MAX : psl2;
        page = 9'd1 << p;
        offs = {1'b0, addr} & (page - 9'd1);
        room = page - offs;
        return (bytes < room) ? bytes : room;
    endfunction

    function automatic result_t mk(input cmd_t c, input logic [7:0] b);
        result_t r;
        r.command    = c;
        r.byte_value = b;
        r.last       = 1'b0;
        return r;
    endfunction

    logic [7:0] wr_addr_byte;
    logic [7:0] rd_addr_byte;

    assign wr_addr_byte = {cfg.device_address, 1'b0};
    assign rd_addr_byte = {cfg.device_address, 1'b1};

    // Advance the sequence by one input and form its results
    always_comb
    begin
        logic [8:0] room;
        logic [8:0] wlen;
        logic [8:0] bytes_dec;
        logic [8:0] chunk_dec;
        nxt       = cur;
        res[0]    = RESULT_NONE;
        res[1]    = RESULT_NONE;
        res[2]    = RESULT_NONE;
        res_count = 2'd0;
        room      = '0;
        wlen      = '0;
        bytes_dec = cur.bytes_left - 9'd1;
        chunk_dec = cur.chunk_left - 9'd1;

        case (cur.phase)
            PH_IDLE:
            begin
                if (opcode == OP_WRITE)
                begin
                    room = ({1'b0, mem_address} < cfg.capacity)
                         ? cfg.capacity - {1'b0, mem_address} : 9'd0;
                    wlen = (length > room) ? room : length;
                    nxt.cur_addr   = mem_address;
                    nxt.bytes_left = wlen;
                    nxt.is_read    = 1'b0;
                    if (wlen == 9'd0)
                    begin
                        res[0]    = mk(CMD_OK, 8'd0);
                        res_count = 2'd1;
                    end
                    else
                    begin
                        nxt.chunk_left = chunk_len(mem_address, wlen, cfg.page_size_log2);
                        res[0]    = mk(CMD_START, 8'd0);
                        res[1]    = mk(CMD_SEND, wr_addr_byte);
                        res_count = 2'd2;
                        nxt.phase = PH_DEVACK;
                    end
                end
                else if (opcode == OP_READ)
                begin
                    nxt.cur_addr   = mem_address;
                    nxt.bytes_left = length;
                    nxt.chunk_left = 9'd0;
                    nxt.is_read    = 1'b1;
                    if (length == 9'd0)
                    begin
                        res[0]    = mk(CMD_OK, 8'd0);
                        res_count = 2'd1;
                    end
                    else
                    begin
                        res[0]    = mk(CMD_START, 8'd0);
                        res[1]    = mk(CMD_SEND, wr_addr_byte);
                        res_count = 2'd2;
                        nxt.phase = PH_DEVACK;
                    end
                end
            end

            PH_DEVACK:
            begin
                if (opcode == OP_RESP)
                begin
                    if (!ack)
                    begin
                        res[0]    = mk(CMD_STOP, 8'd0);
                        res[1]    = mk(CMD_ERR, 8'd0);
                        res_count = 2'd2;
                        nxt.phase = PH_IDLE;
                    end
                    else
                    begin
                        res[0]    = mk(CMD_SEND, cur.cur_addr);
                        res_count = 2'd1;
                        nxt.phase = PH_ADDRACK;
                    end
                end
            end

            PH_ADDRACK:
            begin
                if (opcode == OP_RESP)
                begin
                    if (!ack)
                    begin
                        res[0]    = mk(CMD_STOP, 8'd0);
                        res[1]    = mk(CMD_ERR, 8'd0);
                        res_count = 2'd2;
                        nxt.phase = PH_IDLE;
                    end
                    else if (cur.is_read)
                    begin
                        res[0]    = mk(CMD_START, 8'd0);
                        res[1]    = mk(CMD_SEND, rd_addr_byte);
                        res_count = 2'd2;
                        nxt.phase = PH_RDEVACK;
                    end
                    else
                    begin
                        res[0]    = mk(CMD_NEED, 8'd0);
                        res_count = 2'd1;
                        nxt.phase = PH_NEEDDATA;
                    end
                end
            end

            PH_NEEDDATA:
            begin
                if (opcode == OP_DATA)
                begin
                    res[0]    = mk(CMD_SEND, data_byte);
                    res_count = 2'd1;
                    nxt.phase = PH_DATAACK;
                end
            end

            PH_DATAACK:
            begin
                if (opcode == OP_RESP)
                begin
                    if (!ack)
                    begin
                        res[0]    = mk(CMD_STOP, 8'd0);
                        res[1]    = mk(CMD_ERR, 8'd0);
                        res_count = 2'd2;
                        nxt.phase = PH_IDLE;
                    end
                    else
                    begin
                        nxt.cur_addr   = cur.cur_addr + 8'd1;
                        nxt.bytes_left = bytes_dec;
                        nxt.chunk_left = chunk_dec;
                        if (chunk_dec != 9'd0)
                        begin
                            res[0]    = mk(CMD_NEED, 8'd0);
                            res_count = 2'd1;
                            nxt.phase = PH_NEEDDATA;
                        end
                        else if (bytes_dec == 9'd0)
                        begin
                            res[0]    = mk(CMD_STOP, 8'd0);
                            res[1]    = mk(CMD_OK, 8'd0);
                            res_count = 2'd2;
                            nxt.phase = PH_IDLE;
                        end
                        else
                        begin
                            res[0]    = mk(CMD_STOP, 8'd0);
                            res[1]    = mk(CMD_WAIT, 8'd0);
                            res_count = 2'd2;
                            nxt.phase = PH_WAITDONE;
                        end
                    end
                end
            end

            PH_WAITDONE:
            begin
                // Write cycle over: open the next chunk whatever the ack bit
                if (opcode == OP_RESP)
                begin
                    nxt.chunk_left = chunk_len(cur.cur_addr, cur.bytes_left,
                                               cfg.page_size_log2);
                    res[0]    = mk(CMD_START, 8'd0);
                    res[1]    = mk(CMD_SEND, wr_addr_byte);
                    res_count = 2'd2;
                    nxt.phase = PH_DEVACK;
                end
            end

            PH_RDEVACK:
            begin
                if (opcode == OP_RESP)
                begin
                    if (!ack)
                    begin
                        res[0]    = mk(CMD_STOP, 8'd0);
                        res[1]    = mk(CMD_ERR, 8'd0);
                        res_count = 2'd2;
                        nxt.phase = PH_IDLE;
                    end
                    else
                    begin
                        res[0]    = mk((cur.bytes_left == 9'd1) ? CMD_RDNACK : CMD_RDACK,
                                       8'd0);
                        res_count = 2'd1;
                        nxt.phase = PH_RDATA;
                    end
                end
            end

            PH_RDATA:
            begin
                if (opcode == OP_RESP)
                begin
                    nxt.cur_addr   = cur.cur_addr + 8'd1;
                    nxt.bytes_left = bytes_dec;
                    res[0]         = mk(CMD_RDOUT, data_byte);
                    if (bytes_dec != 9'd0)
                    begin
                        res[1]    = mk((bytes_dec == 9'd1) ? CMD_RDNACK : CMD_RDACK, 8'd0);
                        res_count = 2'd2;
                    end
                    else
                    begin
                        res[1]    = mk(CMD_STOP, 8'd0);
                        res[2]    = mk(CMD_OK, 8'd0);
                        res_count = 2'd3;
                        nxt.phase = PH_IDLE;
                    end
                end
            end

            default:
            begin
                nxt.phase = PH_IDLE;
            end
        endcase

        // Mark the final result of this request
        case (res_count)
            2'd1:    res[0].last = 1'b1;
            2'd2:    res[1].last = 1'b1;
            2'd3:    res[2].last = 1'b1;
            default: ;
        endcase
    end

endmodule

/* src/i2cps_res_queue.sv */
module i2cps_res_queue
    import i2cps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  result_t          push_res [MaxResults],
    input  logic             pop,
    output logic             not_empty,
    output logic             has_room,
    output result_t          head,
    output logic [QCntW-1:0] count
);

    result_t          entry_reg [QDepth];
    logic [QPtrW-1:0] rd_ptr_reg;
    logic [QPtrW-1:0] rd_ptr_next;
    logic [QPtrW-1:0] wr_ptr_reg;
    logic [QPtrW-1:0] wr_ptr_next;
    logic [QCntW-1:0] count_reg;
    logic [QCntW-1:0] count_next;

    assign not_empty = (count_reg != '0);
    assign has_room  = (count_reg <= QCntW'(QDepth - MaxResults));
    assign head      = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    // Advance pointers and fill level
    always_comb
    begin
        rd_ptr_next = rd_ptr_reg + QPtrW'(pop);
        wr_ptr_next = wr_ptr_reg + QPtrW'(push_count);
        count_next  = count_reg + QCntW'(push_count) - QCntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the new results in order behind the tail
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MaxResults; i++)
        begin
            if (2'(i) < push_count)
            begin
                entry_reg[wr_ptr_reg + QPtrW'(i)] <= push_res[i];
            end
        end
    end

endmodule

/* src/i2c_eeprom_page_sequencer.sv */
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    opcode, mem_address, length, data_byte, ack
// out       output     out_valid / out_ready  command, byte_value, last
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each request is decoded in the cycle it is taken; its zero to three results enter a
// four-entry result queue and leave one per cycle while out_ready is high. A request is
// taken whenever the queue holds at most one result, so one request per cycle is
// sustained while the output keeps pace; requests with several results are bounded by the
// single output port. Reset returns the sequencer to idle, empties the queue and restores
// the register values. cfg_ready is always high.
module i2c_eeprom_page_sequencer
    import i2cps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [7:0] mem_address,
    input  logic [8:0] length,
    input  logic [7:0] data_byte,
    input  logic       ack,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] command,
    output logic [7:0] byte_value,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data
);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    seq_state_t       state_reg;
    seq_state_t       state_next;
    seq_state_t       step_state;
    result_t          step_res [MaxResults];
    logic [1:0]       step_count;
    logic [1:0]       push_count;
    logic             in_take;
    logic             out_take;
    logic             q_not_empty;
    logic             q_has_room;
    result_t          q_head;
    logic [QCntW-1:0] q_count;

    assign cfg_ready = 1'b1;
    assign in_ready  = q_has_room;
    assign in_take   = in_valid && in_ready;
    assign out_take  = out_valid && out_ready;

    // Write the addressed register; drop indexes beyond the list
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEVICE_ADDRESS: cfg_next.device_address = cfg_data[6:0];
                REG_PAGE_SIZE_LOG2: cfg_next.page_size_log2 = cfg_data[3:0];
                REG_CAPACITY:       cfg_next.capacity       = cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= DEVICE_ADDRESS_RESET;
            cfg_reg.page_size_log2 <= PAGE_SIZE_LOG2_RESET;
            cfg_reg.capacity       <= CAPACITY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    i2cps_step u_step (
        .cur         (state_reg),
        .cfg         (cfg_reg),
        .opcode      (opcode),
        .mem_address (mem_address),
        .length      (length),
        .data_byte   (data_byte),
        .ack         (ack),
        .nxt         (step_state),
        .res         (step_res),
        .res_count   (step_count)
    );

    // Hold the sequence state unless a request is taken
    always_comb
    begin
        state_next = in_take ? step_state : state_reg;
        push_count = in_take ? step_count : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= PH_IDLE;
            state_reg.cur_addr   <= '0;
            state_reg.bytes_left <= '0;
            state_reg.chunk_left <= '0;
            state_reg.is_read    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    i2cps_res_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_res   (step_res),
        .pop        (out_take),
        .not_empty  (q_not_empty),
        .has_room   (q_has_room),
        .head       (q_head),
        .count      (q_count)
    );

    assign out_valid  = q_not_empty;
    assign command    = q_head.command;
    assign byte_value = q_head.byte_value;
    assign last       = q_head.last;

`ifndef NO_ASSERTIONS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCntW'(QDepth))
        else $error("result queue overfilled");

    a_busy_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase != PH_IDLE |-> state_reg.bytes_left != 9'd0)
        else $error("sequence active with no bytes left");

    a_idle_resp_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && state_reg.phase == PH_IDLE && (opcode == OP_RESP || opcode == OP_DATA)
        |=> q_count <= $past(q_count))
        else $error("result produced for an unexpected request while idle");

    a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_IDLE && !in_take |=> state_reg.phase == PH_IDLE)
        else $error("sequencer left idle without a request");
`endif

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import i2cps_pkg::*;

    // Index with no register behind it; a write there must change nothing
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned PRESSURE_AFTER = 150;
    localparam int unsigned PRESSURE_HOLD  = 150;
    localparam int unsigned PHASE_ITEMS    = 34;

    // Shadow of the sequencer: registers, transfer state and the results still owed
    class seq_scoreboard;
        logic [6:0] dev_addr;
        logic [3:0] page_log2;
        logic [8:0] capacity;
        phase_t     phase;
        logic [7:0] cur_addr;
        logic [8:0] bytes_left;
        logic [8:0] chunk_left;
        logic       reading;
        result_t    owed_results[$];
        int unsigned errors, items_taken, results_checked;
        int unsigned writes, reads, chunks, aborts;

        function new();
            dev_addr   = DEVICE_ADDRESS_RESET;
            page_log2  = PAGE_SIZE_LOG2_RESET;
            capacity   = CAPACITY_RESET;
            phase      = PH_IDLE;
            cur_addr   = '0;
            bytes_left = '0;
            chunk_left = '0;
            reading    = 1'b0;
            errors = 0; items_taken = 0; results_checked = 0;
            writes = 0; reads = 0; chunks = 0; aborts = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void set_reg(logic [1:0] idx, logic [8:0] val);
            case (idx)
                REG_DEVICE_ADDRESS: dev_addr = val[6:0];
                REG_PAGE_SIZE_LOG2: page_log2 = val[3:0];
                REG_CAPACITY:       capacity = val;
                default: ;
            endcase
        endfunction

        function void push_result(cmd_t cmd, logic [7:0] value);
            result_t r;
            r.command    = cmd;
            r.byte_value = value;
            r.last       = 1'b0;
            owed_results.push_back(r);
        endfunction

        // Open a chunk that runs to the end of the page at most
        function void open_chunk();
            logic [3:0] p;
            logic [8:0] page, room;
            p    = (page_log2 > PAGE_LOG2_MAX) ? PAGE_LOG2_MAX : page_log2;
            page = 9'd1 << p;
            room = page - ({1'b0, cur_addr} & (page - 9'd1));
            chunk_left = (bytes_left < room) ? bytes_left : room;
            chunks++;
            push_result(CMD_START, 8'd0);
            push_result(CMD_SEND, {dev_addr, 1'b0});
            phase = PH_DEVACK;
        endfunction

        // Missing ack: drop the transfer with stop and error
        function void abort();
            aborts++;
            push_result(CMD_STOP, 8'd0);
            push_result(CMD_ERR, 8'd0);
            phase = PH_IDLE;
        endfunction

        // Advance the shadow by one accepted request; return how many results it owes
        function int take_request(logic [1:0] op, logic [7:0] addr, logic [8:0] len,
                                  logic [7:0] data, logic ack);
            int         before_n, produced;
            logic [8:0] room;
            before_n = owed_results.size();
            items_taken++;
            case (phase)
                PH_IDLE:
                    if (op == OP_WRITE)
                    begin
                        room = ({1'b0, addr} < capacity) ? capacity - {1'b0, addr} : 9'd0;
                        cur_addr   = addr;
                        bytes_left = (len > room) ? room : len;
                        reading    = 1'b0;
                        writes++;
                        if (bytes_left == 9'd0)
                            push_result(CMD_OK, 8'd0);
                        else
                            open_chunk();
                    end
                    else if (op == OP_READ)
                    begin
                        cur_addr   = addr;
                        bytes_left = len;
                        chunk_left = 9'd0;
                        reading    = 1'b1;
                        reads++;
                        if (len == 9'd0)
                            push_result(CMD_OK, 8'd0);
                        else
                        begin
                            push_result(CMD_START, 8'd0);
                            push_result(CMD_SEND, {dev_addr, 1'b0});
                            phase = PH_DEVACK;
                        end
                    end
                PH_DEVACK:
                    if (op == OP_RESP)
                    begin
                        if (!ack)
                            abort();
                        else
                        begin
                            push_result(CMD_SEND, cur_addr);
                            phase = PH_ADDRACK;
                        end
                    end
                PH_ADDRACK:
                    if (op == OP_RESP)
                    begin
                        if (!ack)
                            abort();
                        else if (reading)
                        begin
                            push_result(CMD_START, 8'd0);
                            push_result(CMD_SEND, {dev_addr, 1'b1});
                            phase = PH_RDEVACK;
                        end
                        else
                        begin
                            push_result(CMD_NEED, 8'd0);
                            phase = PH_NEEDDATA;
                        end
                    end
                PH_NEEDDATA:
                    if (op == OP_DATA)
                    begin
                        push_result(CMD_SEND, data);
                        phase = PH_DATAACK;
                    end
                PH_DATAACK:
                    if (op == OP_RESP)
                    begin
                        if (!ack)
                            abort();
                        else
                        begin
                            cur_addr   = cur_addr + 8'd1;
                            bytes_left = bytes_left - 9'd1;
                            chunk_left = chunk_left - 9'd1;
                            if (chunk_left != 9'd0)
                            begin
                                push_result(CMD_NEED, 8'd0);
                                phase = PH_NEEDDATA;
                            end
                            else
                            begin
                                push_result(CMD_STOP, 8'd0);
                                if (bytes_left == 9'd0)
                                begin
                                    push_result(CMD_OK, 8'd0);
                                    phase = PH_IDLE;
                                end
                                else
                                begin
                                    push_result(CMD_WAIT, 8'd0);
                                    phase = PH_WAITDONE;
                                end
                            end
                        end
                    end
                PH_WAITDONE:
                    if (op == OP_RESP)
                        open_chunk();
                PH_RDEVACK:
                    if (op == OP_RESP)
                    begin
                        if (!ack)
                            abort();
                        else
                        begin
                            push_result(bytes_left == 9'd1 ? CMD_RDNACK : CMD_RDACK, 8'd0);
                            phase = PH_RDATA;
                        end
                    end
                PH_RDATA:
                    if (op == OP_RESP)
                    begin
                        push_result(CMD_RDOUT, data);
                        cur_addr   = cur_addr + 8'd1;
                        bytes_left = bytes_left - 9'd1;
                        if (bytes_left != 9'd0)
                            push_result(bytes_left == 9'd1 ? CMD_RDNACK : CMD_RDACK, 8'd0);
                        else
                        begin
                            push_result(CMD_STOP, 8'd0);
                            push_result(CMD_OK, 8'd0);
                            phase = PH_IDLE;
                        end
                    end
                default: ;
            endcase
            produced = owed_results.size() - before_n;
            if (produced != 0)
                owed_results[owed_results.size() - 1].last = 1'b1;
            return produced;
        endfunction

        // Compare one result against the oldest one owed
        function void check_result(logic [3:0] cmd, logic [7:0] value, logic fin);
            result_t want;
            results_checked++;
            if (owed_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, %s %0d byte 0x%02h last %0b",
                         $time, "actual command", cmd, value, fin);
                return;
            end
            want = owed_results.pop_front();
            if (cmd !== want.command)
            begin
                errors++;
                $display("%0t: command expected %0d actual %0d", $time, want.command, cmd);
            end
            if (value !== want.byte_value)
            begin
                errors++;
                $display("%0t: byte_value expected 0x%02h actual 0x%02h",
                         $time, want.byte_value, value);
            end
            if (fin !== want.last)
            begin
                errors++;
                $display("%0t: last expected %0b actual %0b", $time, want.last, fin);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] opcode = OP_RESP;
    logic [7:0] mem_address = '0;
    logic [8:0] length = '0;
    logic [7:0] data_byte = '0;
    logic       ack = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [3:0] command;
    logic [7:0] byte_value;
    logic       last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [8:0] cfg_data = '0;

    seq_scoreboard sb = new();
    int unsigned   src_burst = 0;
    int unsigned   quiet_cycles = 0;

    i2c_eeprom_page_sequencer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .mem_address(mem_address),
        .length     (length),
        .data_byte  (data_byte),
        .ack        (ack),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .command    (command),
        .byte_value (byte_value),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #10 clk = ~clk;

    // Gap before the next request or stall length: mostly short, a few long,
    // and now and then a stretch with no gaps at all
    function automatic int unsigned gap_cycles(inout int unsigned burst);
        int unsigned r;
        if (burst != 0)
        begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst = $urandom_range(10, 30);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offer one request, hold it until taken, then advance the shadow
    task automatic drive(input logic [1:0] op, input logic [7:0] addr, input logic [8:0] len,
                         input logic [7:0] data, input logic ack_bit, output int produced);
        int unsigned idle;
        idle = gap_cycles(src_burst);
        if (idle != 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        mem_address <= addr;
        length      <= len;
        data_byte   <= data;
        ack         <= ack_bit;
        do @(posedge clk); while (!in_ready);
        produced = sb.take_request(op, addr, len, data, ack_bit);
    endtask

    // Drop valid, wait for every owed result, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(input logic [8:0] dev, input logic [8:0] page,
                             input logic [8:0] cap);
        write_reg(REG_UNUSED, 9'($urandom_range(0, 511)));
        write_reg(REG_DEVICE_ADDRESS, dev);
        write_reg(REG_PAGE_SIZE_LOG2, page);
        write_reg(REG_CAPACITY, cap);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed transfers following the shadow state, some noise;
    // finish the open transfer once enough requests have had an effect
    task automatic run_random(input int unsigned target);
        int unsigned done_cnt, r;
        int          produced;
        logic [1:0]  op;
        logic [7:0]  a, d;
        logic [8:0]  l;
        logic        k;
        done_cnt = 0;
        while (done_cnt < target || sb.phase != PH_IDLE)
        begin
            a = 8'($urandom_range(0, 255));
            l = 9'($urandom_range(0, 256));
            d = 8'($urandom_range(0, 255));
            k = 1'($urandom_range(0, 1));
            if (done_cnt < target && $urandom_range(0, 9) == 0)
            begin
                // Noise: out-of-place responses, data and requests
                if (sb.phase == PH_IDLE)
                    op = $urandom_range(0, 1) ? OP_RESP : OP_DATA;
                else
                    op = 2'($urandom_range(0, 3));
            end
            else
            begin
                case (sb.phase)
                    PH_IDLE:
                    begin
                        op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
                        if ($urandom_range(0, 1))
                            a = 8'($urandom_range(0, sb.capacity - 9'd1));
                        r = $urandom_range(0, 39);
                        if (r == 0)
                            l = 9'd0;
                        else if (r != 1)
                            l = 9'($urandom_range(1, 12));
                    end
                    PH_NEEDDATA:
                        op = OP_DATA;
                    PH_WAITDONE, PH_RDATA:
                        op = OP_RESP;
                    default:
                    begin
                        op = OP_RESP;
                        k  = ($urandom_range(0, 15) != 0);
                    end
                endcase
            end
            drive(op, a, l, d, k, produced);
            if (produced != 0)
                done_cnt++;
        end
    endtask

    // Drain results with random stalls and one long hold-off to back up the block
    initial
    begin : result_sink
        int unsigned hold_left, sink_burst;
        bit          pressure_done;
        hold_left = 0;
        sink_burst = 0;
        pressure_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_result(command, byte_value, last);
            if (hold_left == 0)
            begin
                if (!pressure_done && sb.results_checked >= PRESSURE_AFTER)
                begin
                    hold_left = PRESSURE_HOLD;
                    pressure_done = 1'b1;
                end
                else
                    hold_left = gap_cycles(sink_burst);
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // End the run when nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles++;
    end

    initial
    begin : stimulus
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ignored inputs while idle, zero lengths, clamping at the top
        // of memory, requests and data out of place, read ack/nack, missing acks
        drive(OP_RESP,  8'h00, 9'd0,   8'h00, 1'b1, n);
        drive(OP_DATA,  8'hFF, 9'd256, 8'hFF, 1'b0, n);
        drive(OP_WRITE, 8'h00, 9'd0,   8'h00, 1'b0, n);
        drive(OP_READ,  8'hFF, 9'd0,   8'hFF, 1'b1, n);
        drive(OP_WRITE, 8'hFF, 9'd256, 8'h00, 1'b0, n);
        drive(OP_READ,  8'h10, 9'd4,   8'h00, 1'b0, n);
        drive(OP_RESP,  8'h00, 9'd0,   8'h00, 1'b1, n);
        drive(OP_DATA,  8'h00, 9'd0,   8'h5A, 1'b1, n);
        drive(OP_RESP,  8'h00, 9'd0,   8'h00, 1'b1, n);
        drive(OP_RESP,  8'h00, 9'd0,   8'h00, 1'b1, n);
        drive(OP_DATA,  8'h00, 9'd0,   8'hFF, 1'b0, n);
        drive(OP_RESP,  8'h00, 9'd0,   8'h00, 1'b1, n);
        drive(OP_READ,  8'h07, 9'd2,   8'h00, 1'b0, n);
        drive(OP_RESP,  8'h00, 9'd0,   8'h00, 1'b1, n);
        drive(OP_RESP,  8'h00, 9'd0,   8'h00, 1'b1, n);
        drive(OP_RESP,  8'h00, 9'd0,   8'h00, 1'b1, n);
        drive(OP_RESP,  8'h00, 9'd0,   8'h00, 1'b0, n);
        drive(OP_RESP,  8'h00, 9'd0,   8'hFF, 1'b1, n);
        drive(OP_READ,  8'h00, 9'd1,   8'h00, 1'b0, n);
        drive(OP_RESP,  8'h00, 9'd0,   8'h00, 1'b0, n);
        drive(OP_WRITE, 8'h06, 9'd3,   8'h00, 1'b0, n);
        drive(OP_RESP,  8'h00, 9'd0,   8'h00, 1'b1, n);
        drive(OP_RESP,  8'h00, 9'd0,   8'h00, 1'b0, n);
        run_random(PHASE_ITEMS);
        settle();

        // One-byte pages, top device address
        configure(9'd127, 9'd0, 9'd256);
        run_random(PHASE_ITEMS);
        settle();

        // Whole-memory page, device address zero, reduced capacity
        configure(9'd0, 9'd8, 9'd200);
        run_random(PHASE_ITEMS);
        settle();

        // Page exponent above the maximum, single-byte memory
        configure(9'd37, 9'd15, 9'd1);
        run_random(PHASE_ITEMS);
        settle();

        // Upper data bits set on the narrow registers
        configure(9'h1D5, 9'h1F2, 9'd64);
        run_random(PHASE_ITEMS);
        settle();

        configure(9'd80, 9'd4, 9'd256);
        run_random(PHASE_ITEMS);
        settle();

        $display("Run: %0d requests taken (%0d writes, %0d reads) over six register settings",
                 sb.items_taken, sb.writes, sb.reads);
        $display("Run: %0d page chunks, %0d bus aborts, %0d results compared, %0d mismatches",
                 sb.chunks, sb.aborts, sb.results_checked, sb.errors);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
src/i2cps_pkg.sv
src/i2cps_step.sv
src/i2cps_res_queue.sv
src/i2c_eeprom_page_sequencer.sv
sim/tb_top.sv
